// File: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define AST_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, gated by reset.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/mcad_pkg.sv
// ----------------------------------------------------------------------------
// mcad_pkg
// Shared types and constants of the least-cost descent search block.
// ----------------------------------------------------------------------------
package mcad_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int ALT_W     = 16;
    localparam int DIST_W    = 29;
    localparam int COST_W    = 28;
    localparam int SADDR_W   = 2 * NODE_W;

    localparam logic [DIST_W-1:0] DIST_INF = '1;
    localparam logic              CMD_LOAD = 1'b0;
    localparam logic              CMD_RUN  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_A0_RD,
        ST_A0_LAT,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_PICK_RD,
        ST_PICK_LAT,
        ST_ROW,
        ST_ALTI_LAT,
        ST_REL_RD,
        ST_REL_WR,
        ST_FIN_RD,
        ST_FIN_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_CLR,
        OP_A0_LAT,
        OP_INIT_RD,
        OP_INIT_WR,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_PICK_RD,
        OP_PICK_LAT,
        OP_ROW,
        OP_ALTI_LAT,
        OP_REL_RD,
        OP_REL_WR,
        OP_FIN_CMP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   clr_ij;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        logic i_last;
        logic j_last;
        logic row_bit;
        logic pick_any;
        logic out_free;
    } dp_status_t;

endpackage

// File: hw/rtl/mcad_ctrl.sv
// ----------------------------------------------------------------------------
// mcad_ctrl
// Sequencer for load, clear, seed, select, relax and final reduction.
// ----------------------------------------------------------------------------
module mcad_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                cmd,
    output logic                in_ready,
    input  mcad_pkg::dp_status_t status,
    output mcad_pkg::dp_cmd_t   dp_cmd
);
    import mcad_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        dp_cmd.op     = OP_NONE;
        dp_cmd.clr_ij = 1'b0;
        dp_cmd.emit   = 1'b0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cmd == CMD_RUN)
                    begin
                        dp_cmd.op     = OP_START;
                        dp_cmd.clr_ij = 1'b1;
                        state_next    = ST_CLR;
                    end
                    else
                    begin
                        dp_cmd.op = OP_LOAD;
                    end
                end
            end
            ST_CLR:
            begin
                dp_cmd.op = OP_CLR;
                if (status.i_last && status.j_last)
                begin
                    dp_cmd.clr_ij = 1'b1;
                    state_next    = ST_A0_RD;
                end
            end
            ST_A0_RD:
            begin
                // altitude of node 0 is read while counters sit at zero
                state_next = ST_A0_LAT;
            end
            ST_A0_LAT:
            begin
                dp_cmd.op  = OP_A0_LAT;
                state_next = ST_INIT_RD;
            end
            ST_INIT_RD:
            begin
                dp_cmd.op  = OP_INIT_RD;
                state_next = ST_INIT_WR;
            end
            ST_INIT_WR:
            begin
                dp_cmd.op = OP_INIT_WR;
                if (status.j_last)
                begin
                    dp_cmd.clr_ij = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_INIT_RD;
                end
            end
            ST_SCAN_RD:
            begin
                dp_cmd.op  = OP_SCAN_RD;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                dp_cmd.op = OP_SCAN_CMP;
                if (status.i_last && status.j_last)
                begin
                    dp_cmd.clr_ij = 1'b1;
                    state_next    = status.pick_any ? ST_PICK_RD : ST_FIN_RD;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_PICK_RD:
            begin
                dp_cmd.op  = OP_PICK_RD;
                state_next = ST_PICK_LAT;
            end
            ST_PICK_LAT:
            begin
                dp_cmd.op  = OP_PICK_LAT;
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                dp_cmd.op = OP_ROW;
                if (status.row_bit)
                begin
                    state_next = ST_ALTI_LAT;
                end
                else if (status.i_last)
                begin
                    dp_cmd.clr_ij = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_ALTI_LAT:
            begin
                dp_cmd.op  = OP_ALTI_LAT;
                state_next = ST_REL_RD;
            end
            ST_REL_RD:
            begin
                dp_cmd.op  = OP_REL_RD;
                state_next = ST_REL_WR;
            end
            ST_REL_WR:
            begin
                dp_cmd.op = OP_REL_WR;
                if (status.j_last)
                begin
                    if (status.i_last)
                    begin
                        dp_cmd.clr_ij = 1'b1;
                        state_next    = ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_ROW;
                    end
                end
                else
                begin
                    state_next = ST_REL_RD;
                end
            end
            ST_FIN_RD:
            begin
                state_next = ST_FIN_CMP;
            end
            ST_FIN_CMP:
            begin
                dp_cmd.op  = OP_FIN_CMP;
                state_next = status.j_last ? ST_DONE : ST_FIN_RD;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    dp_cmd.emit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/mcad_datapath.sv
// ----------------------------------------------------------------------------
// mcad_datapath
// Node stores, distance memory, counters and the result register.
// ----------------------------------------------------------------------------
module mcad_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcad_pkg::dp_cmd_t             dp_cmd,
    output mcad_pkg::dp_status_t          status,
    input  logic                          cfg_write_en,
    input  logic [6:0]                    cfg_write_data,
    input  logic [mcad_pkg::NODE_W-1:0]   node_index,
    input  logic [mcad_pkg::ALT_W-1:0]    altitude_value,
    input  logic [mcad_pkg::MAX_NODES-1:0] adjacency_row,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mcad_pkg::COST_W-1:0]   min_cost,
    output logic                          found
);
    import mcad_pkg::*;

    logic [ALT_W-1:0]     alt_mem  [0:MAX_NODES-1];
    logic [MAX_NODES-1:0] adj_mem  [0:MAX_NODES-1];
    logic [DIST_W:0]      dist_mem [0:MAX_NODES*MAX_NODES-1];

    logic [6:0]           node_count_reg;
    logic [CNT_W-1:0]     n_reg, i_reg, i_next, j_reg, j_next;
    logic [ALT_W-1:0]     alt0_reg, alti_reg, cur_alt_reg;
    logic [MAX_NODES-1:0] cur_row_reg;
    logic [DIST_W-1:0]    dpick_reg, best_reg;
    logic [SADDR_W-1:0]   pick_addr_reg;
    logic                 pick_found_reg;
    logic                 out_valid_reg;
    logic [COST_W-1:0]    min_cost_reg;
    logic                 found_reg;

    logic [ALT_W-1:0]     alt_q;
    logic [MAX_NODES-1:0] adj_q;
    logic [DIST_W:0]      dist_q;
    logic [NODE_W-1:0]    alt_raddr, adj_raddr;
    logic [SADDR_W-1:0]   dist_raddr, dist_waddr, ij_addr;
    logic [DIST_W:0]      dist_wdata;
    logic                 dist_we;
    logic [CNT_W-1:0]     n_clamp, n_last;
    logic [ALT_W-1:0]     diff_a0, diff_ai;
    logic [DIST_W-1:0]    cand;
    logic                 scan_hit;

    assign n_last  = n_reg - CNT_W'(1);
    assign ij_addr = {i_reg[NODE_W-1:0], j_reg[NODE_W-1:0]};
    assign diff_a0 = (alt_q >= alt0_reg) ? alt_q - alt0_reg : alt0_reg - alt_q;
    assign diff_ai = (alt_q >= alti_reg) ? alt_q - alti_reg : alti_reg - alt_q;
    assign cand    = dpick_reg + DIST_W'(diff_ai);
    assign scan_hit = !dist_q[DIST_W] && (dist_q[DIST_W-1:0] != DIST_INF) &&
                      (!pick_found_reg || (dist_q[DIST_W-1:0] < dpick_reg));

    always_comb
    begin
        if (node_count_reg < 7'd2)
            n_clamp = CNT_W'(2);
        else if (node_count_reg > 7'(MAX_NODES))
            n_clamp = CNT_W'(MAX_NODES);
        else
            n_clamp = CNT_W'(node_count_reg);
    end

    always_comb
    begin
        status.i_last   = (i_reg == n_last);
        status.j_last   = (j_reg == n_last);
        status.row_bit  = cur_row_reg[i_reg[NODE_W-1:0]];
        status.pick_any = pick_found_reg || scan_hit;
        status.out_free = !out_valid_reg || out_ready;
    end

    // read and write port selection
    always_comb
    begin
        alt_raddr  = j_reg[NODE_W-1:0];
        adj_raddr  = pick_addr_reg[SADDR_W-1:NODE_W];
        dist_raddr = ij_addr;
        dist_waddr = ij_addr;
        dist_wdata = {1'b0, DIST_INF};
        dist_we    = 1'b0;
        unique case (dp_cmd.op)
            OP_CLR:
            begin
                dist_we = 1'b1;
            end
            OP_INIT_WR:
            begin
                dist_waddr = {NODE_W'(0), j_reg[NODE_W-1:0]};
                dist_wdata = {1'b0, DIST_W'(diff_a0)};
                dist_we    = 1'b1;
            end
            OP_SCAN_RD, OP_REL_RD:
            begin
                dist_raddr = ij_addr;
            end
            OP_PICK_RD:
            begin
                alt_raddr  = pick_addr_reg[NODE_W-1:0];
                dist_waddr = pick_addr_reg;
                dist_wdata = {1'b1, dpick_reg};
                dist_we    = 1'b1;
            end
            OP_ROW:
            begin
                alt_raddr = i_reg[NODE_W-1:0];
            end
            OP_REL_WR:
            begin
                dist_wdata = {dist_q[DIST_W], cand};
                dist_we    = (alt_q <= cur_alt_reg) && (cand < dist_q[DIST_W-1:0]);
            end
            default:
            begin
                dist_raddr = {n_last[NODE_W-1:0], j_reg[NODE_W-1:0]};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == OP_LOAD)
        begin
            alt_mem[node_index] <= altitude_value;
            adj_mem[node_index] <= adjacency_row;
        end
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        alt_q  <= alt_mem[alt_raddr];
        adj_q  <= adj_mem[adj_raddr];
        dist_q <= dist_mem[dist_raddr];
    end

    // counter advance: j inner, i outer
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (dp_cmd.clr_ij)
        begin
            i_next = '0;
            j_next = '0;
        end
        else
        begin
            unique case (dp_cmd.op)
                OP_CLR, OP_SCAN_CMP, OP_REL_WR:
                begin
                    if (j_reg == n_last)
                    begin
                        j_next = '0;
                        i_next = i_reg + CNT_W'(1);
                    end
                    else
                    begin
                        j_next = j_reg + CNT_W'(1);
                    end
                end
                OP_INIT_WR, OP_FIN_CMP:
                begin
                    j_next = j_reg + CNT_W'(1);
                end
                OP_ROW:
                begin
                    if (!status.row_bit)
                        i_next = i_reg + CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 7'd2;
            n_reg          <= CNT_W'(2);
            i_reg          <= '0;
            j_reg          <= '0;
            pick_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                node_count_reg <= cfg_write_data;
            if (dp_cmd.op == OP_START)
                n_reg <= n_clamp;
            i_reg <= i_next;
            j_reg <= j_next;
            if (dp_cmd.clr_ij)
                pick_found_reg <= 1'b0;
            else if (dp_cmd.op == OP_SCAN_CMP && scan_hit)
                pick_found_reg <= 1'b1;
            if (dp_cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.clr_ij)
            best_reg <= DIST_INF;
        else if (dp_cmd.op == OP_FIN_CMP && dist_q[DIST_W-1:0] < best_reg)
            best_reg <= dist_q[DIST_W-1:0];
        if (dp_cmd.op == OP_A0_LAT)
            alt0_reg <= alt_q;
        if (dp_cmd.op == OP_SCAN_CMP && scan_hit)
        begin
            dpick_reg     <= dist_q[DIST_W-1:0];
            pick_addr_reg <= ij_addr;
        end
        if (dp_cmd.op == OP_PICK_LAT)
        begin
            cur_row_reg <= adj_q;
            cur_alt_reg <= alt_q;
        end
        if (dp_cmd.op == OP_ALTI_LAT)
            alti_reg <= alt_q;
        if (dp_cmd.emit)
        begin
            found_reg    <= (best_reg != DIST_INF);
            min_cost_reg <= (best_reg != DIST_INF) ? best_reg[COST_W-1:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_cost  = min_cost_reg;
    assign found     = found_reg;

endmodule

// File: hw/rtl/min_cost_altitude_dijkstra.sv
// ----------------------------------------------------------------------------
// min_cost_altitude_dijkstra
// Least-cost descent search over (node, altitude) pairs, dense Dijkstra.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per command. A load
//   beat (cmd 0) writes one node's altitude and adjacency row; loads can
//   stream back to back and give no output beat.
//   A run beat (cmd 1) starts the search and gives exactly one output beat
//   (min_cost, found) on out_valid/out_ready.
//   A run clears the distance memory, seeds the states of node 0, then picks
//   the least unsettled state in turn and relaxes the states of the nodes in
//   its row, and ends with a minimum over the states of the last node.
//   in_ready stays low for the whole run. The result register parts the two
//   sides: a new command is taken while a result still waits, but a run that
//   finishes holds in its last step until the previous result is taken.
//   The user writes node_count through cfg_write_en/cfg_write_data only while
//   idle; the block itself does not enforce it. Reset clears control state and
//   sets node_count to 2; node stores hold whatever was last written.
// ----------------------------------------------------------------------------
module min_cost_altitude_dijkstra (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [6:0]                     cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [mcad_pkg::NODE_W-1:0]    node_index,
    input  logic [mcad_pkg::ALT_W-1:0]     altitude_value,
    input  logic [mcad_pkg::MAX_NODES-1:0] adjacency_row,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mcad_pkg::COST_W-1:0]    min_cost,
    output logic                           found
);
    import mcad_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t status;

    // sequencer: steps of load, clear, seed, select, relax and final reduction
    mcad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_ready (in_ready),
        .status   (status),
        .dp_cmd   (dp_cmd)
    );

    // stores, distance memory, counters and the result register
    mcad_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .node_index     (node_index),
        .altitude_value (altitude_value),
        .adjacency_row  (adjacency_row),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .min_cost       (min_cost),
        .found          (found)
    );

endmodule

// File: hw/rtl/mcad_checker.sv
// ----------------------------------------------------------------------------
// mcad_checker
// Port-level checks of the search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcad_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        cmd,
    input logic        out_valid,
    input logic        out_ready,
    input logic [27:0] min_cost,
    input logic        found
);

    `AST_IMPL(a_nf_zero, out_valid && !found, min_cost == 28'd0)
    `AST_NEXT(a_run_busy, in_valid && in_ready && cmd, !in_ready)
    `AST_NEXT(a_load_fast, in_valid && in_ready && !cmd, in_ready)
    `AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(min_cost))

endmodule

bind min_cost_altitude_dijkstra mcad_checker u_mcad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_cost  (min_cost),
    .found     (found)
);

// File: tb/tb_min_cost_altitude_dijkstra.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_cost_altitude_dijkstra
// Self-checking bench for the least-cost descent search block: streams node
// loads and search runs, predicts each run result in a scoreboard and checks
// every output beat against it in order.
// ----------------------------------------------------------------------------
module tb_min_cost_altitude_dijkstra;
    import mcad_pkg::*;

    localparam logic [28:0] NO_PATH = 29'h1FFF_FFFF;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              reached;
    } search_result_t;

    // Descent search scoreboard: mirrors the node stores and the node count,
    // works out each run's least cost and holds results not yet seen.
    class descent_scoreboard;
        logic [ALT_W-1:0]     alt_mem[MAX_NODES];
        logic [MAX_NODES-1:0] row_mem[MAX_NODES];
        logic [6:0]           count_reg;
        int unsigned          reach_cost[MAX_NODES * MAX_NODES];
        bit                   settled[MAX_NODES * MAX_NODES];
        search_result_t       pending[$];
        int                   errors;

        function new();
            count_reg = 7'd2;
            errors    = 0;
            for (int k = 0; k < MAX_NODES; k++)
            begin
                alt_mem[k] = '0;
                row_mem[k] = '0;
            end
        endfunction

        function void write_count(logic [6:0] value);
            count_reg = value;
        endfunction

        function int unsigned alt_gap(int unsigned p, int unsigned q);
            return (p >= q) ? p - q : q - p;
        endfunction

        function search_result_t search();
            int unsigned    n;
            int unsigned    total;
            int             pick;
            int unsigned    cur_node;
            int unsigned    cur_alt;
            int unsigned    cand;
            int unsigned    best;
            search_result_t res;
            n = count_reg;
            if (n < 2)
                n = 2;
            if (n > MAX_NODES)
                n = MAX_NODES;
            total = n * n;
            for (int s = 0; s < total; s++)
            begin
                reach_cost[s] = NO_PATH;
                settled[s]    = 0;
            end
            // Seed node 0 at every available altitude.
            for (int j = 0; j < n; j++)
                reach_cost[j] = alt_gap(alt_mem[j], alt_mem[0]);
            forever
            begin
                pick = -1;
                for (int s = 0; s < total; s++)
                    if (!settled[s] && reach_cost[s] != NO_PATH &&
                        (pick < 0 || reach_cost[s] < reach_cost[pick]))
                        pick = s;
                if (pick < 0)
                    break;
                settled[pick] = 1;
                cur_node = pick / n;
                cur_alt  = alt_mem[pick % n];
                for (int i = 0; i < n; i++)
                begin
                    if (!row_mem[cur_node][i])
                        continue;
                    for (int j = 0; j < n; j++)
                    begin
                        // Never climb above the current altitude.
                        if (alt_mem[j] > cur_alt)
                            continue;
                        cand = reach_cost[pick] + alt_gap(alt_mem[j], alt_mem[i]);
                        if (cand < reach_cost[i * n + j])
                            reach_cost[i * n + j] = cand;
                    end
                end
            end
            best = NO_PATH;
            for (int j = 0; j < n; j++)
                if (reach_cost[(n - 1) * n + j] < best)
                    best = reach_cost[(n - 1) * n + j];
            res.reached = (best != NO_PATH);
            res.cost    = res.reached ? best[COST_W-1:0] : '0;
            return res;
        endfunction

        function void note_input(logic op, logic [NODE_W-1:0] idx,
                                 logic [ALT_W-1:0] alt, logic [MAX_NODES-1:0] row);
            if (op == CMD_LOAD)
            begin
                alt_mem[idx] = alt;
                row_mem[idx] = row;
            end
            else
                pending.push_back(search());
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(logic [COST_W-1:0] cost, logic reached);
            search_result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected beat cost=%0d found=%0b", cost, reached));
                return;
            end
            want = pending.pop_front();
            if (reached !== want.reached)
                report($sformatf("found %0b, want %0b", reached, want.reached));
            if (cost !== want.cost)
                report($sformatf("min_cost %0d, want %0d", cost, want.cost));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [6:0]           cfg_write_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 cmd;
    logic [NODE_W-1:0]    node_index;
    logic [ALT_W-1:0]     altitude_value;
    logic [MAX_NODES-1:0] adjacency_row;
    logic                 out_valid;
    logic                 out_ready;
    logic [COST_W-1:0]    min_cost;
    logic                 found;

    descent_scoreboard sb;
    bit                calm;     // no idling in the closing stretch
    logic [6:0]        active_n; // node count the stimulus aims at

    min_cost_altitude_dijkstra u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .node_index     (node_index),
        .altitude_value (altitude_value),
        .adjacency_row  (adjacency_row),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .min_cost       (min_cost),
        .found          (found)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Send one beat. An optional idle burst drops valid first; otherwise valid
    // stays high across back-to-back beats. The beat is noted at the edge
    // where it is taken, so the scoreboard sees inputs in order.
    task send_beat(logic op, logic [NODE_W-1:0] idx, logic [ALT_W-1:0] alt,
                   logic [MAX_NODES-1:0] row);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= op;
        node_index     <= idx;
        altitude_value <= alt;
        adjacency_row  <= row;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        sb.note_input(op, idx, alt, row);
        @(negedge clk);
    endtask

    // Park the input side, drain all results, then write the node count.
    // Loads give no beat, so wait for the last one to land before the write.
    task set_node_count(logic [6:0] value);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        sb.write_count(value);
        active_n = (value < 2) ? 7'd2 : (value > MAX_NODES) ? 7'(MAX_NODES) : value;
    endtask

    // Altitude with a bias toward small values so ties and descents are common.
    function automatic logic [ALT_W-1:0] pick_alt();
        case ($urandom_range(0, 3))
            0:       return ALT_W'($urandom_range(0, 65535));
            1:       return ALT_W'($urandom_range(0, 3));
            default: return ALT_W'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [MAX_NODES-1:0] pick_row();
        logic [MAX_NODES-1:0] r;
        r = {$urandom, $urandom};
        // Thin out the live bits so not every run reaches the last node.
        if ($urandom_range(0, 2) != 0)
            r = r & {$urandom, $urandom};
        return r;
    endfunction

    // Hold out_ready low in random bursts, except in the closing stretch.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (calm)
                out_ready <= 1'b1;
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check(min_cost, found);

    initial
    begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int burst;
        sb             = new();
        calm           = 0;
        active_n       = 7'd2;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        cmd            = CMD_LOAD;
        node_index     = '0;
        altitude_value = '0;
        adjacency_row  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Load every node once so no run ever reads an unwritten entry.
        for (int k = 0; k < MAX_NODES; k++)
            send_beat(CMD_LOAD, NODE_W'(k), pick_alt(), pick_row());

        // Directed: node count below range is used as two.
        set_node_count(7'd0);
        send_beat(CMD_LOAD, 6'd0, 16'd0, 64'h2);
        send_beat(CMD_LOAD, 6'd1, 16'd0, '0);
        send_beat(CMD_RUN, 6'd0, '0, '0);
        // Not found: no edge out of node 0.
        send_beat(CMD_LOAD, 6'd0, 16'hFFFF, '0);
        send_beat(CMD_RUN, 6'h3F, 16'hFFFF, '1);
        // Extreme altitudes, full rows including unused and self-loop bits.
        send_beat(CMD_LOAD, 6'd0, 16'hFFFF, '1);
        send_beat(CMD_LOAD, 6'd1, 16'h0000, '1);
        send_beat(CMD_RUN, 6'd0, '0, '0);
        set_node_count(7'd4);
        send_beat(CMD_LOAD, 6'd0, 16'd10, 64'h1);   // self loop only
        send_beat(CMD_LOAD, 6'd1, 16'd5, 64'h9);
        send_beat(CMD_LOAD, 6'd2, 16'd5, 64'h8);
        send_beat(CMD_LOAD, 6'd3, 16'd20, 64'h2);
        send_beat(CMD_RUN, 6'd0, '0, '0);
        send_beat(CMD_LOAD, 6'd0, 16'd10, 64'h6);   // climbing path is blocked
        send_beat(CMD_RUN, 6'd0, '0, '0);
        send_beat(CMD_LOAD, 6'd3, 16'd7, 64'h0);
        send_beat(CMD_LOAD, 6'd63, 16'hFFFF, '1);   // stored, beyond node count
        send_beat(CMD_RUN, 6'd0, '0, '0);

        // Node count above range is used as the maximum. Keep node 0 isolated
        // so each full-size run settles only the seed states.
        set_node_count(7'd127);
        send_beat(CMD_LOAD, 6'd0, 16'd3, '0);
        send_beat(CMD_RUN, 6'd0, '0, '0);
        set_node_count(7'd64);
        send_beat(CMD_LOAD, 6'd0, 16'd0, '0);
        send_beat(CMD_RUN, 6'd0, '0, '0);

        // Random phases at small node counts; the last one runs without idling.
        for (int ph = 0; ph < 16; ph++)
        begin
            set_node_count(7'($urandom_range(2, 6)));
            if (ph == 15)
                calm = 1;
            burst = $urandom_range(30, 60);
            for (int b = 0; b < burst; b++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_beat(CMD_RUN, NODE_W'($urandom_range(0, 63)), ALT_W'($urandom),
                              pick_row());
                else if ($urandom_range(0, 9) == 0)
                    send_beat(CMD_LOAD, NODE_W'($urandom_range(0, 63)), pick_alt(),
                              pick_row());
                else
                    send_beat(CMD_LOAD, NODE_W'($urandom_range(0, active_n - 1)),
                              pick_alt(), pick_row());
            end
            send_beat(CMD_RUN, NODE_W'($urandom_range(0, 63)), ALT_W'($urandom),
                      pick_row());
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mcad_pkg.sv
hw/rtl/mcad_ctrl.sv
hw/rtl/mcad_datapath.sv
hw/rtl/min_cost_altitude_dijkstra.sv
hw/rtl/mcad_checker.sv
tb/tb_min_cost_altitude_dijkstra.sv
